@@ rtl/tcpq_pkg.sv @@
`default_nettype none

package tcpq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned ID_W            = 16;
  localparam int unsigned BATCH_W         = 3;
  localparam int unsigned REM_W           = 7;
  localparam int unsigned ACTION_W        = 2;
  localparam int unsigned MAX_BATCH       = 4;
  localparam int unsigned BATCH_RESET     = 4;

  typedef enum logic [ACTION_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CALL     = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REMOVED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_FULL      = 3'd4,
    ST_POPPED    = 3'd5
  } status_e;

  typedef struct packed {
    op_e             op;
    logic [ID_W-1:0] id;
    logic            fast;
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    status_e          status;
    logic [REM_W-1:0] remaining;
    logic             last;
  } result_t;

  // zero acts as one, anything above the cap acts as the cap
  function automatic logic [BATCH_W-1:0] batch_limit(input logic [BATCH_W-1:0] bs);
    logic [BATCH_W-1:0] lim;
    if (bs == '0) begin
      lim = BATCH_W'(1);
    end else if (bs > BATCH_W'(MAX_BATCH)) begin
      lim = BATCH_W'(MAX_BATCH);
    end else begin
      lim = bs;
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

@@ rtl/tcpq_front.sv @@
`default_nettype none

module tcpq_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [tcpq_pkg::ACTION_W-1:0] action_i,
  input  wire logic [tcpq_pkg::ID_W-1:0]     id_i,
  input  wire logic                         fast_i,
  output logic                              cmd_valid_o,
  output tcpq_pkg::cmd_t                    cmd_o,
  input  wire logic                         cmd_ready_i
);
  import tcpq_pkg::*;

  logic  vld_q, vld_d;
  cmd_t  cmd_q, cmd_d;
  logic  known;
  logic  accept;

  assign in_ready_o  = !vld_q || cmd_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    cmd_d.id   = id_i;
    cmd_d.fast = fast_i;
    cmd_d.op   = OP_REGISTER;
    known      = 1'b1;
    case (op_e'(action_i))
      OP_REGISTER: cmd_d.op = OP_REGISTER;
      OP_REMOVE:   cmd_d.op = OP_REMOVE;
      OP_CALL:     cmd_d.op = OP_CALL;
      // unused action code is dropped here and never reaches the back end
      default:     known = 1'b0;
    endcase
    vld_d = (vld_q && !cmd_ready_i) || (accept && known);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cmd_q <= '0;
    end else begin
      vld_q <= vld_d;
      if (accept && known) begin
        cmd_q <= cmd_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcpq_cmd_fifo.sv @@
`default_nettype none

module tcpq_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  wire tcpq_pkg::cmd_t push_cmd_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output tcpq_pkg::cmd_t      pop_cmd_o
);
  import tcpq_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push;
  logic       do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tcpq_back.sv @@
`default_nettype none

module tcpq_back #(
  parameter int unsigned QueueDepth = tcpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  output logic                              cmd_ready_o,
  input  wire tcpq_pkg::cmd_t               cmd_i,
  input  wire logic [tcpq_pkg::BATCH_W-1:0] batch_size_i,
  output logic                              res_valid_o,
  input  wire logic                         res_ready_i,
  output tcpq_pkg::result_t                 res_o
);
  import tcpq_pkg::*;

  localparam int unsigned IdxW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_EMPTY,
    S_MATCH,
    S_SCAN,
    S_DROP,
    S_POP
  } state_e;

  state_e                 state_q;
  logic [CntW-1:0]        occ_q;
  logic [CntW-1:0]        fast_q;
  cmd_t                   cmd_q;
  logic [BATCH_W-1:0]     lim_q;
  logic [BATCH_W-1:0]     cnt_q;
  logic                   res_valid_q;
  logic                   res_valid_d;
  result_t                res_q;

  // queue cells, head in cell 0; fast-track entries are the first fast_q cells
  logic [ID_W-1:0]        ids_q [QueueDepth];
  logic [QueueDepth-1:0]  match_q;
  logic [QueueDepth-1:0]  drop_q;
  logic [QueueDepth-1:0]  prefix;
  logic [QueueDepth-1:0]  shift_vec;

  logic                   slot_free;
  logic                   res_emit;
  logic                   full;
  logic                   found;
  logic                   drop_fast;
  logic                   pop_last;
  logic                   do_ins;
  logic                   do_drop;
  logic                   do_pop;
  logic [CntW-1:0]        ins_pos;
  logic [CntW-1:0]        fast_m1;
  logic [CntW-1:0]        occ_m1;
  logic [CntW-1:0]        occ_p1;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    slot_free   = !res_valid_q || res_ready_i;
    res_emit    = slot_free && (state_q inside {S_INSERT, S_EMPTY, S_DROP, S_POP});
    res_valid_d = res_emit || (res_valid_q && !res_ready_i);
    full        = (occ_q == CntW'(QueueDepth));
    found       = drop_q[QueueDepth-1];
    fast_m1     = fast_q - CntW'(1);
    occ_m1      = occ_q - CntW'(1);
    occ_p1      = occ_q + CntW'(1);
    drop_fast   = (fast_q != '0) && drop_q[fast_m1[IdxW-1:0]];
    pop_last    = ((cnt_q + BATCH_W'(1)) == lim_q) || (occ_q == CntW'(1));
    ins_pos     = cmd_q.fast ? fast_q : occ_q;
    do_ins      = (state_q == S_INSERT) && slot_free && !full;
    do_drop     = (state_q == S_DROP) && slot_free && found;
    do_pop      = (state_q == S_POP) && slot_free;
    shift_vec   = do_pop ? '1 : drop_q;
  end

  // bit i set when the first match sits at or below cell i: log-depth prefix or
  always_comb begin
    prefix = match_q;
    for (int s = 1; s < int'(QueueDepth); s = s * 2) begin
      prefix = prefix | (prefix << s);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      if (ins_pos == '0) begin
        ids_q[0] <= cmd_q.id;
      end
      for (int i = 1; i < int'(QueueDepth); i++) begin
        if (CntW'(i) == ins_pos) begin
          ids_q[i] <= cmd_q.id;
        end else if (CntW'(i) > ins_pos) begin
          ids_q[i] <= ids_q[i-1];
        end
      end
    end else if (do_drop || do_pop) begin
      for (int i = 0; i < int'(QueueDepth) - 1; i++) begin
        if (shift_vec[i]) begin
          ids_q[i] <= ids_q[i+1];
        end
      end
    end
    if (state_q == S_MATCH) begin
      for (int i = 0; i < int'(QueueDepth); i++) begin
        match_q[i] <= (CntW'(i) < occ_q) && (ids_q[i] == cmd_q.id);
      end
    end
    if (state_q == S_SCAN) begin
      drop_q <= prefix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      fast_q      <= '0;
      cmd_q       <= '0;
      lim_q       <= '0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= res_valid_d;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q <= cmd_i;
            lim_q <= batch_limit(batch_size_i);
            cnt_q <= '0;
            case (cmd_i.op)
              OP_REGISTER: state_q <= S_INSERT;
              OP_REMOVE:   state_q <= (occ_q == '0) ? S_EMPTY : S_MATCH;
              OP_CALL:     state_q <= (occ_q == '0) ? S_EMPTY : S_POP;
              default:     state_q <= S_IDLE;
            endcase
          end
        end
        S_INSERT: begin
          if (slot_free) begin
            res_q.id      <= cmd_q.id;
            res_q.last    <= 1'b1;
            if (full) begin
              res_q.status    <= ST_FULL;
              res_q.remaining <= REM_W'(occ_q);
            end else begin
              res_q.status    <= ST_INSERTED;
              res_q.remaining <= REM_W'(occ_p1);
              occ_q           <= occ_p1;
              if (cmd_q.fast) begin
                fast_q <= fast_q + CntW'(1);
              end
            end
            state_q <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (slot_free) begin
            res_q.id        <= (cmd_q.op == OP_CALL) ? '0 : cmd_q.id;
            res_q.status    <= ST_EMPTY;
            res_q.remaining <= '0;
            res_q.last      <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        S_MATCH: state_q <= S_SCAN;
        S_SCAN:  state_q <= S_DROP;
        S_DROP: begin
          if (slot_free) begin
            res_q.id    <= cmd_q.id;
            res_q.last  <= 1'b1;
            if (found) begin
              res_q.status    <= ST_REMOVED;
              res_q.remaining <= REM_W'(occ_m1);
              occ_q           <= occ_m1;
              if (drop_fast) begin
                fast_q <= fast_m1;
              end
            end else begin
              res_q.status    <= ST_NOT_FOUND;
              res_q.remaining <= REM_W'(occ_q);
            end
            state_q <= S_IDLE;
          end
        end
        S_POP: begin
          if (slot_free) begin
            res_q.id        <= ids_q[0];
            res_q.status    <= ST_POPPED;
            res_q.remaining <= REM_W'(occ_m1);
            res_q.last      <= pop_last;
            occ_q           <= occ_m1;
            if (fast_q != '0) begin
              fast_q <= fast_m1;
            end
            cnt_q <= cnt_q + BATCH_W'(1);
            if (pop_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fast_within_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fast_q <= occ_q)
    else $error("fast-track count exceeds occupancy");

  a_occ_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CntW'(QueueDepth))
    else $error("occupancy beyond queue depth");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_drop |=> (occ_q + CntW'(1)) == $past(occ_q))
    else $error("remove did not shrink the queue by one");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (occ_q != '0))
    else $error("pop sequence running on an empty queue");
`endif

endmodule

`default_nettype wire

@@ rtl/two_class_priority_queue_unit.sv @@
`default_nettype none

// Two-class bounded queue of 16-bit ids. tuser selects the action (register, remove
// by id, call a batch) and the class; a fast-track id is placed behind the other
// fast-track entries and ahead of every regular one, a regular id goes to the tail.
// Each command gives one result, except a call on a non-empty queue, which gives one
// result per popped entry (up to batch_size, a value of 0 acting as 1 and above 4 as
// 4), tlast marking the final one. Once a command reaches the back end, a remove goes
// through latch, parallel compare in every cell, prefix scan for the first match and
// shift; a call pops one entry per result. The back end takes one command at a time;
// the input register and a two-entry command queue in front of it absorb up to three
// more, and a stalled result holds the back end, then the input once those are full.
// Action code 3 is dropped with no result. The user must write batch_size through the
// cfg channel only while the block is idle; the block itself does not enforce this.
module two_class_priority_queue_unit #(
  parameter int unsigned QueueDepth = tcpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // passenger_id[15:0]
  input  wire logic [2:0]  s_axis_tuser,   // action[1:0], express[2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // out_id[15:0], remaining[22:16], zero[23]
  output logic [2:0]       m_axis_tuser,   // status[2:0]
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_data_i      // batch_size
);
  import tcpq_pkg::*;

  logic [BATCH_W-1:0] batch_q;
  logic               front_valid;
  logic               front_ready;
  cmd_t               front_cmd;
  logic               fifo_valid;
  logic               fifo_ready;
  cmd_t               fifo_cmd;
  result_t            res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q <= BATCH_W'(BATCH_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      batch_q <= cfg_data_i;
    end
  end

  tcpq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser[1:0]),
    .id_i        (s_axis_tdata),
    .fast_i      (s_axis_tuser[2]),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd),
    .cmd_ready_i (front_ready)
  );

  tcpq_cmd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (fifo_valid),
    .pop_ready_i  (fifo_ready),
    .pop_cmd_o    (fifo_cmd)
  );

  tcpq_back #(
    .QueueDepth (QueueDepth)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (fifo_valid),
    .cmd_ready_o  (fifo_ready),
    .cmd_i        (fifo_cmd),
    .batch_size_i (batch_q),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {1'b0, res.remaining, res.id};
  assign m_axis_tuser = res.status;
  assign m_axis_tlast = res.last;

endmodule

`default_nettype wire
